// ===== rtl/ptp_pkg.sv =====
// shared types, constants and arithmetic helpers of the puck trajectory predictor
`default_nettype none

package ptp_pkg;

    // sample set and trajectory limits
    localparam int MAX_POINTS = 32;
    localparam int TRAJ_STEPS = 64;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int STEP_W     = $clog2(TRAJ_STEPS + 1);

    // stream payload widths
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 96;

    // configuration port
    localparam int          APB_AW      = 3;
    localparam int          CFG_W       = 23;
    localparam logic [22:0] WIDTH_RESET = 23'd163840;
    localparam logic        REG_RADIUS  = 1'b0;
    localparam logic        REG_WIDTH   = 1'b1;

    localparam logic signed [23:0] SMAX24 = 24'sh7FFFFF;
    localparam logic signed [23:0] SMIN24 = 24'sh800000;

    // result kinds
    typedef enum logic [1:0] {
        KIND_TRAJ   = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_ERR    = 2'd2,
        KIND_NOTRAJ = 2'd3
    } t_kind;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NOP,
        OP_MUL_XX,
        OP_ACC_XY,
        OP_ACC_END,
        OP_FIT1,
        OP_FIT2,
        OP_FIT3,
        OP_MUL_DLO,
        OP_MUL_DHI,
        OP_DIV_SETX,
        OP_DIV_STEP,
        OP_DIV_FINX,
        OP_DIV_FINY,
        OP_WALK,
        OP_ERR,
        OP_NOTRAJ,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load_in;
    } t_cmd;

    typedef struct packed {
        logic in_tick;
        logic in_drop;
        logic in_last;
        logic n_lt2;
        logic degen;
        logic div_done;
        logic y_pos;
        logic walk_last;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic               hit;
        logic signed [26:0] pos;
    } t_wall;

    // saturate to the signed 24-bit range
    function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
        if (v > 27'sd8388607) begin
            return SMAX24;
        end else if (v < -27'sd8388608) begin
            return SMIN24;
        end else begin
            return v[23:0];
        end
    endfunction

    // negate with saturation
    function automatic logic signed [23:0] neg_sat(input logic signed [23:0] v);
        if (v == SMIN24) begin
            return SMAX24;
        end else begin
            return -v;
        end
    endfunction

    // -(3*v/4), division truncating toward zero
    function automatic logic signed [23:0] refl34(input logic signed [23:0] v);
        logic signed [25:0] t;
        logic signed [25:0] q;
        t = 26'(v) + 26'(v) + 26'(v);
        if (t < 0) begin
            t = t + 26'sd3;
        end
        q = -(t >>> 2);
        return q[23:0];
    endfunction

    // side wall test, left wall first
    function automatic t_wall wall_clamp(input logic signed [26:0] px,
                                         input logic [22:0] r,
                                         input logic [22:0] w);
        t_wall              res;
        logic signed [26:0] rs;
        logic signed [26:0] ws;
        rs = $signed({4'b0, r});
        ws = $signed({4'b0, w});
        res.hit = 1'b1;
        if (px - rs < 0) begin
            res.pos = rs;
        end else if (px + rs > ws) begin
            res.pos = ws - rs;
        end else begin
            res.hit = 1'b0;
            res.pos = px;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ptp_dp.sv =====
// datapath: accumulators, shared multipliers, restoring divider, walk and output register
`default_nettype none

module ptp_dp (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire ptp_pkg::t_cmd            i_cmd,
    output ptp_pkg::t_stat                o_stat,
    input  wire logic [47:0]              i_s_data,
    input  wire logic                     i_s_type,
    input  wire logic                     i_s_last,
    input  wire logic [22:0]              i_radius,
    input  wire logic [22:0]              i_width,
    input  wire logic                     i_m_ready,
    output logic                          o_m_valid,
    output logic [95:0]                   o_m_data,
    output logic [1:0]                    o_m_kind,
    output logic                          o_m_last
);
    import ptp_pkg::*;

    // latched input item
    logic               r_in_type;
    logic               r_in_last;
    logic signed [23:0] r_in_x;
    logic signed [23:0] r_in_y;

    // sums and stored puck state
    logic [CNT_W-1:0]   r_cnt;
    logic signed [29:0] r_sx;
    logic signed [29:0] r_sy;
    logic signed [54:0] r_sxy;
    logic signed [54:0] r_sxx;
    logic signed [23:0] r_fy;
    logic signed [24:0] r_px;
    logic signed [23:0] r_py;
    logic signed [23:0] r_vx;
    logic signed [23:0] r_vy;

    // fit intermediates
    logic signed [65:0] r_prod;
    logic signed [66:0] r_np;
    logic [4:0]         r_nm1;
    logic signed [59:0] r_d;
    logic signed [59:0] r_b;
    logic signed [24:0] r_dy;
    logic               r_negx;

    // divider
    logic [81:0]        r_num;
    logic [86:0]        r_dsh;
    logic [24:0]        r_q;
    logic [4:0]         r_k;
    logic               r_divdone;

    // trajectory walk
    logic signed [24:0] r_wx;
    logic signed [23:0] r_wy;
    logic signed [23:0] r_wvx;
    logic [STEP_W-1:0]  r_wcnt;

    // output register
    logic               r_ov;
    t_kind              r_okind;
    logic signed [23:0] r_opx;
    logic signed [23:0] r_opy;
    logic signed [23:0] r_ovx;
    logic signed [23:0] r_ovy;
    logic               r_olast;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [59:0] nm_a;
    logic [5:0]         nm_b;
    logic signed [66:0] nm_p;
    logic signed [59:0] abs_d;
    logic signed [59:0] abs_b;
    logic [24:0]        abs_dy;
    logic               div_ge;
    logic               out_free;
    logic               load_out;

    logic signed [26:0] t_sx;
    logic signed [23:0] t_py;
    t_wall              t_hit;
    logic signed [23:0] t_vx;
    logic signed [26:0] w_sx;
    logic signed [23:0] w_ny;
    t_wall              w_hit;
    logic signed [23:0] w_vx;
    logic               walk_last;

    // magnitudes
    assign abs_d  = r_d[59] ? -r_d : r_d;
    assign abs_b  = r_b[59] ? -r_b : r_b;
    assign abs_dy = r_dy[24] ? 25'(-r_dy) : 25'(r_dy);

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        nm_a  = '0;
        nm_b  = '0;
        case (i_cmd.op)
            OP_MUL_XX: begin
                mul_a = 33'(r_in_x);
                mul_b = 33'(r_in_x);
            end
            OP_ACC_XY: begin
                mul_a = 33'(r_in_x);
                mul_b = 33'(r_in_y);
            end
            OP_FIT1: begin
                mul_a = 33'(r_sx);
                mul_b = 33'(r_sx);
                nm_a  = 60'(r_sxx);
                nm_b  = r_cnt;
            end
            OP_FIT2: begin
                mul_a = 33'(r_sx);
                mul_b = 33'(r_sy);
                nm_a  = 60'(r_sxy);
                nm_b  = r_cnt;
            end
            OP_MUL_DLO: begin
                mul_a = $signed({8'b0, abs_dy});
                mul_b = $signed({4'b0, abs_d[28:0]});
            end
            OP_MUL_DHI: begin
                mul_a = $signed({8'b0, abs_dy});
                mul_b = $signed({4'b0, abs_d[57:29]});
                nm_a  = $signed({2'b0, abs_b[57:0]});
                nm_b  = {1'b0, r_nm1};
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign nm_p  = nm_a * $signed({1'b0, nm_b});

    // divider compare
    assign div_ge = ({5'b0, r_num} >= r_dsh);

    // tick step with full reflection
    always_comb begin
        t_sx  = 27'(r_px) + 27'(r_vx);
        t_py  = sat24(27'(r_py) + 27'(r_vy));
        t_hit = wall_clamp(t_sx, i_radius, i_width);
        t_vx  = t_hit.hit ? neg_sat(r_vx) : r_vx;
    end

    // trajectory step with damped reflection
    always_comb begin
        w_sx      = 27'(r_wx) + 27'(r_wvx);
        w_ny      = sat24(27'(r_wy) + 27'(r_vy));
        w_hit     = wall_clamp(w_sx, i_radius, i_width);
        w_vx      = w_hit.hit ? refl34(r_wvx) : r_wvx;
        walk_last = (w_ny <= 0) || (r_wcnt == STEP_W'(TRAJ_STEPS - 1));
    end

    assign out_free = !r_ov || i_m_ready;
    assign load_out = (i_cmd.op == OP_WALK) || (i_cmd.op == OP_ERR) ||
                      (i_cmd.op == OP_NOTRAJ) || (i_cmd.op == OP_TICK);

    // status to the controller
    always_comb begin
        o_stat.in_tick   = r_in_type;
        o_stat.in_drop   = !r_in_last && (r_cnt >= CNT_W'(MAX_POINTS - 1));
        o_stat.in_last   = r_in_last;
        o_stat.n_lt2     = (r_cnt < CNT_W'(2));
        o_stat.degen     = (r_d == '0) || (r_b == '0);
        o_stat.div_done  = r_q[24] || r_divdone;
        o_stat.y_pos     = (r_wy > 0);
        o_stat.walk_last = walk_last;
        o_stat.out_free  = out_free;
    end

    // sums, stored puck state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxy <= '0;
            r_sxx <= '0;
            r_fy  <= '0;
            r_px  <= '0;
            r_py  <= '0;
            r_vx  <= '0;
            r_vy  <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (i_m_ready) begin
                r_ov <= 1'b0;
            end
            case (i_cmd.op)
                OP_ACC_XY: begin
                    if (r_cnt == '0) begin
                        r_fy <= r_in_y;
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    r_sx  <= r_sx + 30'(r_in_x);
                    r_sy  <= r_sy + 30'(r_in_y);
                    r_sxx <= r_sxx + r_prod[54:0];
                end
                OP_ACC_END: begin
                    r_sxy <= r_sxy + r_prod[54:0];
                end
                OP_FIT3, OP_ERR: begin
                    r_cnt <= '0;
                    r_sx  <= '0;
                    r_sy  <= '0;
                    r_sxy <= '0;
                    r_sxx <= '0;
                    r_fy  <= '0;
                end
                OP_DIV_FINX: begin
                    r_vx <= sat24(r_negx ? -27'($signed({1'b0, r_q}))
                                         :  27'($signed({1'b0, r_q})));
                end
                OP_DIV_FINY: begin
                    r_vy <= sat24(r_dy[24] ? -27'($signed({1'b0, r_q}))
                                           :  27'($signed({1'b0, r_q})));
                    r_px <= 25'(r_in_x);
                    r_py <= r_in_y;
                end
                OP_TICK: begin
                    r_px <= t_hit.pos[24:0];
                    r_py <= t_py;
                    r_vx <= t_vx;
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        r_np   <= nm_p;
        if (i_cmd.load_in) begin
            r_in_type <= i_s_type;
            r_in_last <= i_s_last;
            r_in_x    <= i_s_data[23:0];
            r_in_y    <= i_s_data[47:24];
        end
        case (i_cmd.op)
            OP_FIT1: begin
                r_nm1 <= 5'(r_cnt - CNT_W'(1));
            end
            OP_FIT2: begin
                r_d <= r_np[59:0] - r_prod[59:0];
            end
            OP_FIT3: begin
                r_b  <= r_np[59:0] - r_prod[59:0];
                r_dy <= 25'(r_in_y) - 25'(r_fy);
            end
            OP_MUL_DLO: begin
                r_negx <= r_dy[24] ^ r_d[59] ^ r_b[59];
            end
            OP_MUL_DHI: begin
                r_num <= {28'b0, r_prod[53:0]};
            end
            OP_DIV_SETX: begin
                r_num     <= r_num + {r_prod[52:0], 29'b0};
                r_dsh     <= {r_np[62:0], 24'b0};
                r_q       <= '0;
                r_k       <= 5'd24;
                r_divdone <= 1'b0;
            end
            OP_DIV_STEP: begin
                if (div_ge) begin
                    r_num    <= r_num - r_dsh[81:0];
                    r_q[r_k] <= 1'b1;
                end
                r_dsh <= r_dsh >> 1;
                if (r_k == '0) begin
                    r_divdone <= 1'b1;
                end else begin
                    r_k <= r_k - 5'd1;
                end
            end
            OP_DIV_FINX: begin
                r_num     <= {57'b0, abs_dy};
                r_dsh     <= {58'b0, r_nm1, 24'b0};
                r_q       <= '0;
                r_k       <= 5'd24;
                r_divdone <= 1'b0;
            end
            OP_DIV_FINY: begin
                r_wx   <= 25'(r_in_x);
                r_wy   <= r_in_y;
                r_wvx  <= r_vx;
                r_wcnt <= '0;
            end
            OP_WALK: begin
                r_wx   <= w_hit.pos[24:0];
                r_wy   <= w_ny;
                r_wvx  <= w_vx;
                r_wcnt <= r_wcnt + STEP_W'(1);
            end
            default: begin
                r_nm1 <= r_nm1;
            end
        endcase

        // output payload
        case (i_cmd.op)
            OP_WALK: begin
                r_okind <= KIND_TRAJ;
                r_opx   <= w_hit.pos[23:0];
                r_opy   <= w_ny;
                r_ovx   <= r_vx;
                r_ovy   <= r_vy;
                r_olast <= walk_last;
            end
            OP_ERR: begin
                r_okind <= KIND_ERR;
                r_opx   <= '0;
                r_opy   <= '0;
                r_ovx   <= '0;
                r_ovy   <= '0;
                r_olast <= 1'b1;
            end
            OP_NOTRAJ: begin
                r_okind <= KIND_NOTRAJ;
                r_opx   <= r_px[23:0];
                r_opy   <= r_py;
                r_ovx   <= r_vx;
                r_ovy   <= r_vy;
                r_olast <= 1'b1;
            end
            OP_TICK: begin
                r_okind <= KIND_TICK;
                r_opx   <= t_hit.pos[23:0];
                r_opy   <= t_py;
                r_ovx   <= t_vx;
                r_ovy   <= r_vy;
                r_olast <= 1'b1;
            end
            default: begin
                r_olast <= r_olast;
            end
        endcase
    end

    assign o_m_valid = r_ov;
    assign o_m_data  = {r_ovy, r_ovx, r_opy, r_opx};
    assign o_m_kind  = r_okind;
    assign o_m_last  = r_olast;

endmodule

`default_nettype wire

// ===== rtl/ptp_ctrl.sv =====
// controller: sequences accumulation, fit, divisions, trajectory walk and ticks
`default_nettype none

module ptp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_valid,
    output logic                o_s_ready,
    input  wire ptp_pkg::t_stat i_stat,
    output ptp_pkg::t_cmd       o_cmd
);
    import ptp_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE   = 18'h00001,
        S_DEC    = 18'h00002,
        S_XY     = 18'h00004,
        S_END    = 18'h00008,
        S_FIT1   = 18'h00010,
        S_FIT2   = 18'h00020,
        S_FIT3   = 18'h00040,
        S_CHK    = 18'h00080,
        S_MLO    = 18'h00100,
        S_MHI    = 18'h00200,
        S_DSETX  = 18'h00400,
        S_DIVX   = 18'h00800,
        S_DIVY   = 18'h01000,
        S_WSTART = 18'h02000,
        S_WALK   = 18'h04000,
        S_ERR    = 18'h08000,
        S_NOTRAJ = 18'h10000,
        S_TICK   = 18'h20000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_s_ready = (r_state == S_IDLE);
    assign accept    = i_s_valid && o_s_ready;

    // next state and datapath command
    always_comb begin
        n_state       = r_state;
        o_cmd.op      = OP_NOP;
        o_cmd.load_in = accept;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.op = OP_MUL_XX;
                if (i_stat.in_tick) begin
                    n_state = S_TICK;
                end else if (i_stat.in_drop) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_XY;
                end
            end
            S_XY: begin
                o_cmd.op = OP_ACC_XY;
                n_state  = S_END;
            end
            S_END: begin
                o_cmd.op = OP_ACC_END;
                n_state  = i_stat.in_last ? S_FIT1 : S_IDLE;
            end
            S_FIT1: begin
                if (i_stat.n_lt2) begin
                    n_state = S_ERR;
                end else begin
                    o_cmd.op = OP_FIT1;
                    n_state  = S_FIT2;
                end
            end
            S_FIT2: begin
                o_cmd.op = OP_FIT2;
                n_state  = S_FIT3;
            end
            S_FIT3: begin
                o_cmd.op = OP_FIT3;
                n_state  = S_CHK;
            end
            S_CHK: begin
                n_state = i_stat.degen ? S_ERR : S_MLO;
            end
            S_MLO: begin
                o_cmd.op = OP_MUL_DLO;
                n_state  = S_MHI;
            end
            S_MHI: begin
                o_cmd.op = OP_MUL_DHI;
                n_state  = S_DSETX;
            end
            S_DSETX: begin
                o_cmd.op = OP_DIV_SETX;
                n_state  = S_DIVX;
            end
            S_DIVX: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_DIV_FINX;
                    n_state  = S_DIVY;
                end else begin
                    o_cmd.op = OP_DIV_STEP;
                end
            end
            S_DIVY: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_DIV_FINY;
                    n_state  = S_WSTART;
                end else begin
                    o_cmd.op = OP_DIV_STEP;
                end
            end
            S_WSTART: begin
                n_state = i_stat.y_pos ? S_WALK : S_NOTRAJ;
            end
            S_WALK: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_WALK;
                    if (i_stat.walk_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_ERR;
                    n_state  = S_IDLE;
                end
            end
            S_NOTRAJ: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_NOTRAJ;
                    n_state  = S_IDLE;
                end
            end
            S_TICK: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_TICK;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/puck_trajectory_predictor_unit.sv =====
// top level: configuration registers, controller and datapath of the puck trajectory predictor
`default_nettype none

// Takes one item at a time. A sampled point occupies the block for the accept plus three
// steps that share one 33x33 multiplier to build the sums; a point that is dropped because
// the set is full leaves after the accept and the decode step. The point marked last then
// runs the fit: multiplies and subtractions, one check, two restoring divisions (one
// quotient bit per cycle, velocity x then velocity y; the x division ends early when it
// saturates) and one step to start the walk before the first predicted point is offered;
// predicted points then leave one per cycle while the output is taken, up to 64 of them.
// A tick runs the decode step and then the tick step once the output is free. An error or
// no-trajectory result is a single transfer with tlast set. Registers: puck_radius at
// byte address 0, rink_width at byte address 4.
module puck_trajectory_predictor_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [ptp_pkg::S_DATA_W-1:0]    s_axis_tdata,  // pt_x, pt_y
    input  wire logic                            s_axis_tuser,  // req_type
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [ptp_pkg::M_DATA_W-1:0]         m_axis_tdata,  // pos_x, pos_y, vel_x, vel_y
    output logic [1:0]                           m_axis_tuser,  // kind
    output logic                                 m_axis_tlast,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ptp_pkg::APB_AW-1:0]      paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import ptp_pkg::*;

    logic [CFG_W-1:0] r_radius;
    logic [CFG_W-1:0] r_width;
    logic             cfg_wr;
    t_cmd             cmd;
    t_stat            stat;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            r_width  <= WIDTH_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_RADIUS) begin
                r_radius <= pwdata[CFG_W-1:0];
            end else begin
                r_width <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_WIDTH) ? {9'b0, r_width} : {9'b0, r_radius};

    ptp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    ptp_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_s_data  (s_axis_tdata),
        .i_s_type  (s_axis_tuser),
        .i_s_last  (s_axis_tlast),
        .i_radius  (r_radius),
        .i_width   (r_width),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_m_data  (m_axis_tdata),
        .o_m_kind  (m_axis_tuser),
        .o_m_last  (m_axis_tlast)
    );

`ifndef ASSERT_OFF
    // one item at a time: no transfer right after an accepted one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while previous item in progress");

    // error results carry zero payload and close the run
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_ERR)) |->
        ((m_axis_tdata == '0) && m_axis_tlast))
        else $error("fit error result with nonzero payload or open run");

    // single-result kinds always close the run
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && ((m_axis_tuser == KIND_TICK) || (m_axis_tuser == KIND_NOTRAJ)))
        |-> m_axis_tlast)
        else $error("tick or no-trajectory result without tlast");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_puck_trajectory_predictor_unit.sv =====
// self-checking testbench of the puck trajectory predictor unit
`timescale 1ns / 100ps

module tb_puck_trajectory_predictor_unit;
    import ptp_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 100;

    typedef struct {
        t_kind       kind;
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [23:0] vel_x;
        logic [23:0] vel_y;
        logic        last;
    } t_puck_res;

    // directed stimulus row, with a typed expectation where it is obvious
    typedef struct {
        bit          tick;
        logic [23:0] x;
        logic [23:0] y;
        bit          last;
        bit          typed;
        t_kind       kind;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;  // pt_x, pt_y
    logic                s_axis_tuser;  // req_type
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;  // pos_x, pos_y, vel_x, vel_y
    logic [1:0]          m_axis_tuser;  // kind
    logic                m_axis_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    puck_trajectory_predictor_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // mirror of the block state
    longint    n_pts, sum_x, sum_y, sum_xy, sum_xx, y_first;
    longint    puck_x, puck_y, puck_vx, puck_vy;
    longint    radius_q, width_q;
    t_puck_res predicted_q[$];
    int        n_errors;
    int        hold_len;
    bit        no_idle;

    function automatic longint clip24(input longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic logic [63:0] magn(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic void push_res(input t_kind k, input longint px, input longint py,
                                     input longint vx, input longint vy, input bit lst);
        t_puck_res r;
        r.kind  = k;
        r.pos_x = px[23:0];
        r.pos_y = py[23:0];
        r.vel_x = vx[23:0];
        r.vel_y = vy[23:0];
        r.last  = lst;
        predicted_q = {predicted_q, r};
    endfunction

    function automatic void clear_sums();
        n_pts = 0; sum_x = 0; sum_y = 0; sum_xy = 0; sum_xx = 0; y_first = 0;
    endfunction

    // line fit on the closing point, then the trajectory walk
    function automatic void fit_and_walk(input longint x, input longint y);
        longint       n, d, b, dy, px, py, pvx, vq;
        logic [127:0] num, den, q;
        bit           neg;
        int           steps;
        n = n_pts;
        if (n < 2) begin
            clear_sums();
            push_res(KIND_ERR, 0, 0, 0, 0, 1);
            return;
        end
        d  = n * sum_xx - sum_x * sum_x;
        b  = n * sum_xy - sum_x * sum_y;
        dy = y - y_first;
        clear_sums();
        if (d == 0 || b == 0) begin
            push_res(KIND_ERR, 0, 0, 0, 0, 1);
            return;
        end
        neg = (dy < 0) != ((d < 0) != (b < 0));
        num = 128'(magn(dy)) * 128'(magn(d));
        den = 128'(magn(b)) * 128'(n - 1);
        q   = num / den;
        if (q > 128'(1 << 24)) q = 128'(1 << 24);
        vq      = longint'(q[63:0]);
        puck_vx = clip24(neg ? -vq : vq);
        puck_vy = clip24(dy / (n - 1));
        puck_x  = x;
        puck_y  = y;
        px = puck_x; py = puck_y; pvx = puck_vx;
        steps = 0;
        while (py > 0 && steps < TRAJ_STEPS) begin
            px += pvx;
            py = clip24(py + puck_vy);
            if (px - radius_q < 0) begin
                px = radius_q; pvx = -((3 * pvx) / 4);
            end else if (px + radius_q > width_q) begin
                px = width_q - radius_q; pvx = -((3 * pvx) / 4);
            end
            steps++;
            push_res(KIND_TRAJ, px, py, puck_vx, puck_vy, steps == TRAJ_STEPS || py <= 0);
        end
        if (steps == 0) push_res(KIND_NOTRAJ, puck_x, puck_y, puck_vx, puck_vy, 1);
    endfunction

    // expected results of one accepted item
    function automatic void predict_puck(input bit tick, input logic [23:0] xr,
                                         input logic [23:0] yr, input bit lst);
        longint x, y;
        x = longint'($signed(xr));
        y = longint'($signed(yr));
        if (tick) begin
            puck_x += puck_vx;
            puck_y = clip24(puck_y + puck_vy);
            if (puck_x - radius_q < 0) begin
                puck_x = radius_q; puck_vx = clip24(-puck_vx);
            end else if (puck_x + radius_q > width_q) begin
                puck_x = width_q - radius_q; puck_vx = clip24(-puck_vx);
            end
            push_res(KIND_TICK, puck_x, puck_y, puck_vx, puck_vy, 1);
            return;
        end
        if (!lst && n_pts >= MAX_POINTS - 1) return;
        if (n_pts == 0) y_first = y;
        sum_x  += x;
        sum_y  += y;
        sum_xy += x * y;
        sum_xx += x * x;
        n_pts++;
        if (lst) fit_and_walk(x, y);
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // one item transfer on the input stream
    task automatic send_item(input bit tick, input logic [23:0] x, input logic [23:0] y,
                             input bit lst, input bit typed, input t_kind k);
        int        gap;
        t_puck_res scratch[$];
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = tick;
        s_axis_tlast  = lst;
        s_axis_tdata  = {y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        if (typed) begin
            scratch = predicted_q;
            predict_puck(tick, x, y, lst);
            predicted_q = scratch;
            push_res(k, 0, 0, 0, 0, 1);
        end else begin
            predict_puck(tick, x, y, lst);
        end
    endtask

    // wait until every result is in, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        wait (predicted_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic set_rink(input longint r, input longint w);
        reg_write({REG_RADIUS, 2'b00}, 32'(r));
        reg_write({REG_WIDTH, 2'b00}, 32'(w));
        radius_q = r;
        width_q  = w;
    endtask

    // a well-formed sample set along a noisy line
    task automatic send_set(input int n);
        longint x0, y0, dx, dyv, x, y;
        x0  = $urandom_range(0, 200000);
        y0  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3000) : $urandom_range(20000, 300000);
        dx  = longint'($urandom_range(0, 6000)) - 3000;
        dyv = -longint'($urandom_range(300, 9000));
        for (int i = 0; i < n; i++) begin
            x = x0 + i * dx + $urandom_range(0, 3);
            y = y0 + i * dyv + $urandom_range(0, 3);
            send_item(1'b0, x[23:0], y[23:0], i == n - 1, 1'b0, KIND_TRAJ);
        end
    endtask

    task automatic random_phase(input int items);
        int sent, pick, n;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(31, 40) : $urandom_range(2, 8);
                send_set(n);
                sent += n;
            end else if (pick < 85) begin
                send_item(1'b1, 24'($urandom), 24'($urandom), $urandom_range(0, 1), 1'b0, KIND_TICK);
                sent++;
            end else begin
                send_item(1'b0, 24'($urandom), 24'($urandom), $urandom_range(0, 1), 1'b0, KIND_TRAJ);
                sent++;
            end
        end
    endtask

    t_row dir_rows[20] = '{
        '{1'b1, 24'd0,      24'd0,      1'b0, 1'b1, KIND_TICK},
        '{1'b0, 24'd5,      24'd7,      1'b1, 1'b1, KIND_ERR},
        '{1'b0, 24'd100,    24'd10,     1'b0, 1'b0, KIND_TRAJ},
        '{1'b0, 24'd100,    24'd500,    1'b1, 1'b1, KIND_ERR},
        '{1'b0, 24'd0,      24'd300,    1'b0, 1'b0, KIND_TRAJ},
        '{1'b0, 24'd256,    24'd300,    1'b1, 1'b1, KIND_ERR},
        '{1'b0, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b0, KIND_TRAJ},
        '{1'b0, 24'h800000, 24'h800000, 1'b1, 1'b0, KIND_TRAJ},
        '{1'b0, 24'h800000, 24'h7FFFFF, 1'b0, 1'b0, KIND_TRAJ},
        '{1'b0, 24'h7FFFFF, 24'h000001, 1'b1, 1'b0, KIND_TRAJ},
        '{1'b0, 24'd20000,  24'd40000,  1'b0, 1'b0, KIND_TRAJ},
        '{1'b0, 24'd20500,  24'd38000,  1'b0, 1'b0, KIND_TRAJ},
        '{1'b0, 24'd21000,  24'd36000,  1'b1, 1'b0, KIND_TRAJ},
        '{1'b1, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0, KIND_TICK},
        '{1'b1, 24'd0,      24'd0,      1'b0, 1'b0, KIND_TICK},
        '{1'b0, 24'd80000,  24'd5000,   1'b0, 1'b0, KIND_TRAJ},
        '{1'b0, 24'd80100,  24'd0,      1'b1, 1'b0, KIND_TRAJ},
        '{1'b0, 24'd1000,   24'd90000,  1'b0, 1'b0, KIND_TRAJ},
        '{1'b0, 24'd0,      24'd80000,  1'b1, 1'b0, KIND_TRAJ},
        '{1'b1, 24'd0,      24'd0,      1'b0, 1'b0, KIND_TICK}
    };

    // stimulus
    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0; s_axis_tlast = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        n_errors = 0; hold_len = 0; no_idle = 1'b0;
        radius_q = 0; width_q = 163840;
        clear_sums();
        puck_x = 0; puck_y = 0; puck_vx = 0; puck_vy = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].tick, dir_rows[i].x, dir_rows[i].y, dir_rows[i].last,
                      dir_rows[i].typed, dir_rows[i].kind);
        random_phase(80);
        drain();

        // wide rink, no radius; the receiver holds off while points keep coming
        set_rink(0, 8388607);
        hold_len = 400;
        random_phase(90);
        drain();

        // radius larger than the rink, back to back transfers
        set_rink(8388607, 0);
        no_idle = 1'b1;
        random_phase(70);
        drain();
        no_idle = 1'b0;

        set_rink(1280, 163840);
        random_phase(90);
        drain();

        set_rink($urandom_range(0, 4000), $urandom_range(100000, 400000));
        random_phase(70);
        drain();

        if (n_errors == 0 && predicted_q.size() == 0) begin
            $display("puck_trajectory_predictor_unit test passed");
        end else begin
            $display("puck_trajectory_predictor_unit test failed");
        end
        $finish;
    end

    // result side: random stalls and field checks
    initial begin
        int        stall;
        t_puck_res exp_r;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_len > 0) begin
                stall = hold_len;
                hold_len = 0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 15);
            end
            @(negedge i_clk);
            m_axis_tready = 1'b0;
            repeat (stall) @(negedge i_clk);
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            if (predicted_q.size() == 0) begin
                $error("result transfer with nothing expected");
                n_errors++;
            end else begin
                exp_r = predicted_q.pop_front();
                if (m_axis_tuser != exp_r.kind) begin
                    $error("kind: expected %0d, got %0d", exp_r.kind, m_axis_tuser);
                    n_errors++;
                end
                if (m_axis_tdata[23:0] != exp_r.pos_x) begin
                    $error("pos_x: expected %h, got %h", exp_r.pos_x, m_axis_tdata[23:0]);
                    n_errors++;
                end
                if (m_axis_tdata[47:24] != exp_r.pos_y) begin
                    $error("pos_y: expected %h, got %h", exp_r.pos_y, m_axis_tdata[47:24]);
                    n_errors++;
                end
                if (m_axis_tdata[71:48] != exp_r.vel_x) begin
                    $error("vel_x: expected %h, got %h", exp_r.vel_x, m_axis_tdata[71:48]);
                    n_errors++;
                end
                if (m_axis_tdata[95:72] != exp_r.vel_y) begin
                    $error("vel_y: expected %h, got %h", exp_r.vel_y, m_axis_tdata[95:72]);
                    n_errors++;
                end
                if (m_axis_tlast != exp_r.last) begin
                    $error("last_of_run: expected %0d, got %0d", exp_r.last, m_axis_tlast);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("puck_trajectory_predictor_unit test failed");
                $finish;
            end
        end
    end

endmodule
